@@ rtl/rtn_pkg.sv @@
// ----------------------------------------------------------------------------
// rtn_pkg
// Shared types and constants of the ray/triangle nearest-hit block.
// ----------------------------------------------------------------------------
package rtn_pkg;

    localparam int COORD_W = 32;
    localparam int EXT_W   = 33;
    localparam int WIDE_W  = 48;
    localparam int DIST_W  = 31;
    localparam int BARY_W  = 17;
    localparam int IDX_W   = 12;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [DIST_W-1:0] FAR_LIMIT_RST = 31'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DET_THR_RST   = 31'd1;
    localparam logic [COORD_W-1:0] DIR_Z_RST    = 32'h0001_0000;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex0_x;
        logic signed [COORD_W-1:0] vertex0_y;
        logic signed [COORD_W-1:0] vertex0_z;
        logic signed [COORD_W-1:0] vertex1_x;
        logic signed [COORD_W-1:0] vertex1_y;
        logic signed [COORD_W-1:0] vertex1_z;
        logic signed [COORD_W-1:0] vertex2_x;
        logic signed [COORD_W-1:0] vertex2_y;
        logic signed [COORD_W-1:0] vertex2_z;
        logic                      last_triangle;
    } in_t;

    typedef struct packed {
        logic              hit_found;
        logic [DIST_W-1:0] hit_distance;
        logic [BARY_W-1:0] hit_bary_u;
        logic [BARY_W-1:0] hit_bary_v;
        logic [IDX_W-1:0]  hit_triangle_index;
    } out_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] origin;
        logic [2:0][COORD_W-1:0] dir;
        logic [DIST_W-1:0]       far_limit;
        logic [DIST_W-1:0]       det_threshold;
    } ray_cfg_t;

    // edge1, edge2 and origin-minus-v0, exact 33-bit values
    typedef struct packed {
        logic [2:0][EXT_W-1:0] e1;
        logic [2:0][EXT_W-1:0] e2;
        logic [2:0][EXT_W-1:0] tv;
        logic                  last;
    } job_t;

endpackage

@@ rtl/rtn_queue.sv @@
// ----------------------------------------------------------------------------
// rtn_queue
// Two-entry queue of prepared triangle jobs between front and back.
// ----------------------------------------------------------------------------
module rtn_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  rtn_pkg::job_t in_job,
    output logic          out_valid,
    input  logic          out_ready,
    output rtn_pkg::job_t out_job
);

    rtn_pkg::job_t mem_reg [2];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          push;
    logic          pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_job   = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_job;
        end
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule

@@ rtl/rtn_front.sv @@
// ----------------------------------------------------------------------------
// rtn_front
// Accepts triangles and forms the exact edge and origin vectors.
// ----------------------------------------------------------------------------
module rtn_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtn_pkg::ray_cfg_t cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  rtn_pkg::in_t      s_payload,
    output logic              job_valid,
    input  logic              job_ready,
    output rtn_pkg::job_t     job
);

    rtn_pkg::job_t job_reg;
    rtn_pkg::job_t job_next;
    logic          job_valid_reg;

    function automatic logic [rtn_pkg::EXT_W-1:0] diff(
        input logic [rtn_pkg::COORD_W-1:0] a,
        input logic [rtn_pkg::COORD_W-1:0] b
    );
        diff = {a[rtn_pkg::COORD_W-1], a} - {b[rtn_pkg::COORD_W-1], b};
    endfunction

    always_comb begin
        job_next.e1[0] = diff(s_payload.vertex1_x, s_payload.vertex0_x);
        job_next.e1[1] = diff(s_payload.vertex1_y, s_payload.vertex0_y);
        job_next.e1[2] = diff(s_payload.vertex1_z, s_payload.vertex0_z);
        job_next.e2[0] = diff(s_payload.vertex2_x, s_payload.vertex0_x);
        job_next.e2[1] = diff(s_payload.vertex2_y, s_payload.vertex0_y);
        job_next.e2[2] = diff(s_payload.vertex2_z, s_payload.vertex0_z);
        job_next.tv[0] = diff(cfg.origin[0], s_payload.vertex0_x);
        job_next.tv[1] = diff(cfg.origin[1], s_payload.vertex0_y);
        job_next.tv[2] = diff(cfg.origin[2], s_payload.vertex0_z);
        job_next.last  = s_payload.last_triangle;
    end

    assign s_ready   = !job_valid_reg || job_ready;
    assign job_valid = job_valid_reg;
    assign job       = job_reg;

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            job_reg <= job_next;
        end
        if (!aresetn) begin
            job_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            job_valid_reg <= 1'b1;
        end else if (job_ready) begin
            job_valid_reg <= 1'b0;
        end
    end

endmodule

@@ rtl/rtn_back.sv @@
// ----------------------------------------------------------------------------
// rtn_back
// Intersection engine: shared 48x16 multiplier sequenced by a step table,
// restoring divider, nearest-hit tracking and result register.
// ----------------------------------------------------------------------------
module rtn_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  rtn_pkg::ray_cfg_t cfg,
    input  logic              q_valid,
    output logic              q_ready,
    input  rtn_pkg::job_t     q_job,
    output logic              m_valid,
    input  logic              m_ready,
    output rtn_pkg::out_t     m_payload
);

    localparam int W = rtn_pkg::WIDE_W;
    localparam logic signed [W-1:0] LIM = 48'sh7FFF_FFFF_FFFF;

    typedef enum logic [4:0] {
        OP_DIR0, OP_DIR1, OP_DIR2,
        OP_E1_0, OP_E1_1, OP_E1_2,
        OP_E2_0, OP_E2_1, OP_E2_2,
        OP_TV0,  OP_TV1,  OP_TV2,
        OP_PV0,  OP_PV1,  OP_PV2,
        OP_QV0,  OP_QV1,  OP_QV2
    } opnd_e;

    typedef struct packed {
        opnd_e a;
        opnd_e b;
        logic  first;
        logic  sub;
        logic  fin;
    } uop_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_WB, ST_DIV, ST_FIN
    } state_e;

    typedef enum logic [1:0] { DIV_U, DIV_V, DIV_T } div_sel_e;

    localparam logic [4:0] STEP_PV0 = 5'd1;
    localparam logic [4:0] STEP_PV1 = 5'd3;
    localparam logic [4:0] STEP_PV2 = 5'd5;
    localparam logic [4:0] STEP_DET = 5'd8;
    localparam logic [4:0] STEP_UN  = 5'd11;
    localparam logic [4:0] STEP_QV0 = 5'd13;
    localparam logic [4:0] STEP_QV1 = 5'd15;
    localparam logic [4:0] STEP_QV2 = 5'd17;
    localparam logic [4:0] STEP_VN  = 5'd20;
    localparam logic [4:0] STEP_TN  = 5'd23;

    function automatic uop_t ucode(input logic [4:0] step);
        unique case (step)
            5'd0:    ucode = '{OP_DIR1, OP_E2_2, 1'b1, 1'b0, 1'b0};
            5'd1:    ucode = '{OP_DIR2, OP_E2_1, 1'b0, 1'b1, 1'b1};
            5'd2:    ucode = '{OP_DIR2, OP_E2_0, 1'b1, 1'b0, 1'b0};
            5'd3:    ucode = '{OP_DIR0, OP_E2_2, 1'b0, 1'b1, 1'b1};
            5'd4:    ucode = '{OP_DIR0, OP_E2_1, 1'b1, 1'b0, 1'b0};
            5'd5:    ucode = '{OP_DIR1, OP_E2_0, 1'b0, 1'b1, 1'b1};
            5'd6:    ucode = '{OP_E1_0, OP_PV0,  1'b1, 1'b0, 1'b0};
            5'd7:    ucode = '{OP_E1_1, OP_PV1,  1'b0, 1'b0, 1'b0};
            5'd8:    ucode = '{OP_E1_2, OP_PV2,  1'b0, 1'b0, 1'b1};
            5'd9:    ucode = '{OP_TV0,  OP_PV0,  1'b1, 1'b0, 1'b0};
            5'd10:   ucode = '{OP_TV1,  OP_PV1,  1'b0, 1'b0, 1'b0};
            5'd11:   ucode = '{OP_TV2,  OP_PV2,  1'b0, 1'b0, 1'b1};
            5'd12:   ucode = '{OP_TV1,  OP_E1_2, 1'b1, 1'b0, 1'b0};
            5'd13:   ucode = '{OP_TV2,  OP_E1_1, 1'b0, 1'b1, 1'b1};
            5'd14:   ucode = '{OP_TV2,  OP_E1_0, 1'b1, 1'b0, 1'b0};
            5'd15:   ucode = '{OP_TV0,  OP_E1_2, 1'b0, 1'b1, 1'b1};
            5'd16:   ucode = '{OP_TV0,  OP_E1_1, 1'b1, 1'b0, 1'b0};
            5'd17:   ucode = '{OP_TV1,  OP_E1_0, 1'b0, 1'b1, 1'b1};
            5'd18:   ucode = '{OP_DIR0, OP_QV0,  1'b1, 1'b0, 1'b0};
            5'd19:   ucode = '{OP_DIR1, OP_QV1,  1'b0, 1'b0, 1'b0};
            5'd20:   ucode = '{OP_DIR2, OP_QV2,  1'b0, 1'b0, 1'b1};
            5'd21:   ucode = '{OP_E2_0, OP_QV0,  1'b1, 1'b0, 1'b0};
            5'd22:   ucode = '{OP_E2_1, OP_QV1,  1'b0, 1'b0, 1'b0};
            5'd23:   ucode = '{OP_E2_2, OP_QV2,  1'b0, 1'b0, 1'b1};
            default: ucode = '{OP_DIR0, OP_DIR0, 1'b1, 1'b0, 1'b1};
        endcase
    endfunction

    state_e   state_reg;
    logic [4:0] step_reg;
    logic [1:0] digit_reg;
    logic [95:0] prod_reg;
    logic signed [49:0] acc_reg;

    logic [2:0][rtn_pkg::COORD_W-1:0] dir_reg;
    logic [2:0][rtn_pkg::EXT_W-1:0]   e1_reg;
    logic [2:0][rtn_pkg::EXT_W-1:0]   e2_reg;
    logic [2:0][rtn_pkg::EXT_W-1:0]   tv_reg;
    logic [2:0][W-1:0]                pv_reg;
    logic [2:0][W-1:0]                qv_reg;
    logic                             last_reg;

    logic signed [W-1:0] det_reg;
    logic signed [W-1:0] un_reg;
    logic signed [W-1:0] vn_reg;
    logic signed [W-1:0] tn_reg;

    div_sel_e    div_sel_reg;
    logic [5:0]  div_cnt_reg;
    logic [47:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [63:0] quot_reg;
    logic [rtn_pkg::BARY_W-1:0] uq_reg;
    logic [rtn_pkg::BARY_W-1:0] vq_reg;

    logic [rtn_pkg::DIST_W-1:0] best_dist_reg;
    logic [rtn_pkg::BARY_W-1:0] best_u_reg;
    logic [rtn_pkg::BARY_W-1:0] best_v_reg;
    logic [rtn_pkg::IDX_W-1:0]  best_idx_reg;
    logic                       any_hit_reg;
    logic [rtn_pkg::IDX_W-1:0]  tri_cnt_reg;

    logic          m_valid_reg;
    rtn_pkg::out_t m_payload_reg;

    uop_t              uop;
    logic [17:0][W-1:0] ops;
    logic signed [W-1:0] opa;
    logic signed [W-1:0] opb;
    logic [W-1:0]      mag_a;
    logic [W-1:0]      mag_b;
    logic [15:0]       digit;
    logic [63:0]       pp;
    logic [95:0]       pp_sh;
    logic              neg;
    logic [79:0]       qpart;
    logic signed [W-1:0] mq_mag;
    logic signed [W-1:0] mq;
    logic signed [49:0] acc_base;
    logic signed [49:0] acc_sum;
    logic signed [W-1:0] sat_val;
    logic signed [W:0]  un_vn;
    logic              ok;
    logic [48:0]       rem_sh;
    logic              ge;
    logic [48:0]       rem_sub;
    logic [63:0]       quot_fin;
    logic              t_ok;

    function automatic logic [W-1:0] sx33(input logic [rtn_pkg::EXT_W-1:0] x);
        sx33 = {{(W-rtn_pkg::EXT_W){x[rtn_pkg::EXT_W-1]}}, x};
    endfunction

    function automatic logic [W-1:0] sx32(input logic [rtn_pkg::COORD_W-1:0] x);
        sx32 = {{(W-rtn_pkg::COORD_W){x[rtn_pkg::COORD_W-1]}}, x};
    endfunction

    function automatic logic [63:0] div_load(input logic signed [W-1:0] num);
        div_load = {1'b0, num[46:0], 16'b0};
    endfunction

    always_comb begin
        uop = ucode(step_reg);
        ops[OP_DIR0] = sx32(dir_reg[0]);
        ops[OP_DIR1] = sx32(dir_reg[1]);
        ops[OP_DIR2] = sx32(dir_reg[2]);
        ops[OP_E1_0] = sx33(e1_reg[0]);
        ops[OP_E1_1] = sx33(e1_reg[1]);
        ops[OP_E1_2] = sx33(e1_reg[2]);
        ops[OP_E2_0] = sx33(e2_reg[0]);
        ops[OP_E2_1] = sx33(e2_reg[1]);
        ops[OP_E2_2] = sx33(e2_reg[2]);
        ops[OP_TV0]  = sx33(tv_reg[0]);
        ops[OP_TV1]  = sx33(tv_reg[1]);
        ops[OP_TV2]  = sx33(tv_reg[2]);
        ops[OP_PV0]  = pv_reg[0];
        ops[OP_PV1]  = pv_reg[1];
        ops[OP_PV2]  = pv_reg[2];
        ops[OP_QV0]  = qv_reg[0];
        ops[OP_QV1]  = qv_reg[1];
        ops[OP_QV2]  = qv_reg[2];
        opa   = ops[uop.a];
        opb   = ops[uop.b];
        mag_a = opa[W-1] ? -opa : opa;
        mag_b = opb[W-1] ? -opb : opb;
        neg   = opa[W-1] ^ opb[W-1];
        digit = mag_b[{digit_reg, 4'b0} +: 16];
        pp    = mag_a * digit;
        pp_sh = {32'b0, pp} << {digit_reg, 4'b0};

        qpart  = prod_reg[95:16];
        mq_mag = (|qpart[79:47]) ? LIM : {1'b0, qpart[46:0]};
        mq     = neg ? -mq_mag : mq_mag;
        acc_base = uop.first ? 50'sd0 : acc_reg;
        acc_sum  = uop.sub ? acc_base - {{2{mq[W-1]}}, mq}
                           : acc_base + {{2{mq[W-1]}}, mq};

        if (acc_reg > $signed({2'b00, LIM})) begin
            sat_val = LIM;
        end else if (acc_reg < -$signed({2'b00, LIM})) begin
            sat_val = -LIM;
        end else begin
            sat_val = acc_reg[W-1:0];
        end
        un_vn = {un_reg[W-1], un_reg} + {sat_val[W-1], sat_val};

        case (step_reg)
            STEP_DET: ok = (sat_val > 0) &&
                           (sat_val >= $signed({17'b0, cfg.det_threshold}));
            STEP_UN:  ok = (sat_val >= 0) && (sat_val <= det_reg);
            STEP_VN:  ok = (sat_val >= 0) && (un_vn <= {det_reg[W-1], det_reg});
            STEP_TN:  ok = (sat_val > 0);
            default:  ok = 1'b1;
        endcase

        rem_sh   = {rem_reg, dvd_reg[63]};
        ge       = rem_sh >= {1'b0, det_reg};
        rem_sub  = rem_sh - {1'b0, det_reg};
        quot_fin = {quot_reg[62:0], ge};
        t_ok     = (quot_fin != 64'd0) && (quot_fin[63:31] == 33'd0) &&
                   (quot_fin[30:0] <= best_dist_reg);
    end

    assign q_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            m_valid_reg   <= 1'b0;
            best_dist_reg <= rtn_pkg::FAR_LIMIT_RST;
            best_u_reg    <= '0;
            best_v_reg    <= '0;
            best_idx_reg  <= '0;
            any_hit_reg   <= 1'b0;
            tri_cnt_reg   <= '0;
            step_reg      <= '0;
            digit_reg     <= '0;
            div_sel_reg   <= DIV_U;
            div_cnt_reg   <= '0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (q_valid) begin
                        e1_reg    <= q_job.e1;
                        e2_reg    <= q_job.e2;
                        tv_reg    <= q_job.tv;
                        last_reg  <= q_job.last;
                        dir_reg   <= cfg.dir;
                        step_reg  <= '0;
                        digit_reg <= '0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    prod_reg  <= ((digit_reg == 2'd0) ? 96'd0 : prod_reg) + pp_sh;
                    digit_reg <= digit_reg + 2'd1;
                    if (digit_reg == 2'd2) begin
                        digit_reg <= '0;
                        state_reg <= ST_ACC;
                    end
                end
                ST_ACC: begin
                    acc_reg <= acc_sum;
                    if (uop.fin) begin
                        state_reg <= ST_WB;
                    end else begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_WB: begin
                    case (step_reg)
                        STEP_PV0: pv_reg[0] <= sat_val;
                        STEP_PV1: pv_reg[1] <= sat_val;
                        STEP_PV2: pv_reg[2] <= sat_val;
                        STEP_DET: det_reg   <= sat_val;
                        STEP_UN:  un_reg    <= sat_val;
                        STEP_QV0: qv_reg[0] <= sat_val;
                        STEP_QV1: qv_reg[1] <= sat_val;
                        STEP_QV2: qv_reg[2] <= sat_val;
                        STEP_VN:  vn_reg    <= sat_val;
                        STEP_TN:  tn_reg    <= sat_val;
                        default: ;
                    endcase
                    if (!ok) begin
                        state_reg <= ST_FIN;
                    end else if (step_reg == STEP_TN) begin
                        div_sel_reg <= DIV_U;
                        div_cnt_reg <= '0;
                        rem_reg     <= '0;
                        quot_reg    <= '0;
                        dvd_reg     <= div_load(un_reg);
                        state_reg   <= ST_DIV;
                    end else begin
                        step_reg  <= step_reg + 5'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_DIV: begin
                    rem_reg     <= ge ? rem_sub[47:0] : rem_sh[47:0];
                    dvd_reg     <= {dvd_reg[62:0], 1'b0};
                    quot_reg    <= quot_fin;
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd63) begin
                        rem_reg  <= '0;
                        quot_reg <= '0;
                        unique case (div_sel_reg)
                            DIV_U: begin
                                uq_reg      <= quot_fin[rtn_pkg::BARY_W-1:0];
                                dvd_reg     <= div_load(vn_reg);
                                div_sel_reg <= DIV_V;
                            end
                            DIV_V: begin
                                vq_reg      <= quot_fin[rtn_pkg::BARY_W-1:0];
                                dvd_reg     <= div_load(tn_reg);
                                div_sel_reg <= DIV_T;
                            end
                            default: begin
                                if (t_ok) begin
                                    best_dist_reg <= quot_fin[rtn_pkg::DIST_W-1:0];
                                    best_u_reg    <= uq_reg;
                                    best_v_reg    <= vq_reg;
                                    best_idx_reg  <= tri_cnt_reg;
                                    any_hit_reg   <= 1'b1;
                                end
                                state_reg <= ST_FIN;
                            end
                        endcase
                    end
                end
                ST_FIN: begin
                    if (!last_reg) begin
                        tri_cnt_reg <= tri_cnt_reg + 1'b1;
                        state_reg   <= ST_IDLE;
                    end else if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_payload_reg.hit_found <= any_hit_reg;
                        m_payload_reg.hit_distance <= any_hit_reg ? best_dist_reg : '0;
                        m_payload_reg.hit_bary_u <= any_hit_reg ? best_u_reg : '0;
                        m_payload_reg.hit_bary_v <= any_hit_reg ? best_v_reg : '0;
                        m_payload_reg.hit_triangle_index <=
                            any_hit_reg ? best_idx_reg : '0;
                        best_dist_reg <= cfg.far_limit;
                        best_u_reg    <= '0;
                        best_v_reg    <= '0;
                        best_idx_reg  <= '0;
                        any_hit_reg   <= 1'b0;
                        tri_cnt_reg   <= '0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

@@ rtl/ray_triangle_nearest_hit_top.sv @@
// ----------------------------------------------------------------------------
// ray_triangle_nearest_hit_top
// Nearest-hit ray/triangle test over a triangle stream, ray in APB registers.
// ----------------------------------------------------------------------------
//  channel   | direction | payload
//  s_*       | in        | in_t, one triangle per transfer
//  m_*       | out       | out_t, one result per last triangle
//  apb       | in        | eight 32-bit registers at 4*i
//
//  A triangle takes 24 products in the back engine on the shared 48x16
//  multiplier, then three divisions when the numerator tests pass;
//  rejected triangles end early. The front and a two-entry queue keep
//  taking transfers while the engine works, until both are full.
//  Reset is synchronous; the result register holds until m_ready.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  rtn_pkg::in_t               s_payload,
    output logic                       m_valid,
    input  logic                       m_ready,
    output rtn_pkg::out_t              m_payload,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [rtn_pkg::ADDR_W-1:0] paddr,
    input  logic [rtn_pkg::DATA_W-1:0] pwdata,
    output logic [rtn_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_ORIGIN_Z  = 3'd2;
    localparam logic [2:0] REG_DIR_X     = 3'd3;
    localparam logic [2:0] REG_DIR_Y     = 3'd4;
    localparam logic [2:0] REG_DIR_Z     = 3'd5;
    localparam logic [2:0] REG_FAR_LIMIT = 3'd6;
    localparam logic [2:0] REG_DET_THR   = 3'd7;

    rtn_pkg::ray_cfg_t cfg_reg;
    logic [2:0]        reg_idx;
    logic              wr_en;
    logic              job_valid;
    logic              job_ready;
    rtn_pkg::job_t     job;
    logic              q_valid;
    logic              q_ready;
    rtn_pkg::job_t     q_job;

    assign pready  = 1'b1;
    assign reg_idx = paddr[rtn_pkg::ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        unique case (reg_idx)
            REG_ORIGIN_X:  prdata = cfg_reg.origin[0];
            REG_ORIGIN_Y:  prdata = cfg_reg.origin[1];
            REG_ORIGIN_Z:  prdata = cfg_reg.origin[2];
            REG_DIR_X:     prdata = cfg_reg.dir[0];
            REG_DIR_Y:     prdata = cfg_reg.dir[1];
            REG_DIR_Z:     prdata = cfg_reg.dir[2];
            REG_FAR_LIMIT: prdata = {1'b0, cfg_reg.far_limit};
            REG_DET_THR:   prdata = {1'b0, cfg_reg.det_threshold};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.origin        <= '0;
            cfg_reg.dir[0]        <= '0;
            cfg_reg.dir[1]        <= '0;
            cfg_reg.dir[2]        <= rtn_pkg::DIR_Z_RST;
            cfg_reg.far_limit     <= rtn_pkg::FAR_LIMIT_RST;
            cfg_reg.det_threshold <= rtn_pkg::DET_THR_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_ORIGIN_X:  cfg_reg.origin[0]     <= pwdata;
                REG_ORIGIN_Y:  cfg_reg.origin[1]     <= pwdata;
                REG_ORIGIN_Z:  cfg_reg.origin[2]     <= pwdata;
                REG_DIR_X:     cfg_reg.dir[0]        <= pwdata;
                REG_DIR_Y:     cfg_reg.dir[1]        <= pwdata;
                REG_DIR_Z:     cfg_reg.dir[2]        <= pwdata;
                REG_FAR_LIMIT: cfg_reg.far_limit     <= pwdata[rtn_pkg::DIST_W-1:0];
                REG_DET_THR:   cfg_reg.det_threshold <= pwdata[rtn_pkg::DIST_W-1:0];
                default: ;
            endcase
        end
    end

    rtn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    rtn_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (job_valid),
        .in_ready  (job_ready),
        .in_job    (job),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_job   (q_job)
    );

    rtn_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_job     (q_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload)
    );

endmodule

@@ tb/tb_ray_triangle_nearest_hit_top.sv @@
// ----------------------------------------------------------------------------
// tb_ray_triangle_nearest_hit_top
// Checks the nearest-hit ray/triangle block against a fixed-point predictor.
// A short directed table runs first, then phases of random triangle lists,
// each under a new ray and new limits set through APB. Both channels stall
// at random outside phases 5 to 7; every result is compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_ray_triangle_nearest_hit_top;

    localparam longint SAT_LIM   = 64'sh7FFF_FFFF_FFFF;
    localparam int     IDX_WRAP  = 4096;
    localparam int     DRAIN_CYC = 400;
    localparam int     CYC_LIMIT = 6000000;

    typedef enum int {
        REG_ORG_X, REG_ORG_Y, REG_ORG_Z, REG_DIR_X, REG_DIR_Y, REG_DIR_Z,
        REG_FAR_LIMIT, REG_DET_THR
    } reg_idx_e;

    typedef struct {
        rtn_pkg::in_t  triangle;
        bit            typed;
        rtn_pkg::out_t want;
    } row_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic s_valid = 0;
    logic s_ready;
    rtn_pkg::in_t  s_payload = '0;
    logic m_valid;
    logic m_ready = 0;
    rtn_pkg::out_t m_payload;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [rtn_pkg::ADDR_W-1:0] paddr = '0;
    logic [rtn_pkg::DATA_W-1:0] pwdata = '0;
    logic [rtn_pkg::DATA_W-1:0] prdata;
    logic pready;

    ray_triangle_nearest_hit_top dut (.*);

    always #1 aclk = ~aclk;

    // ray and search state as the block should hold them
    longint                     ray_org[3], ray_dir[3];
    logic [rtn_pkg::DIST_W-1:0] far_lim, det_thr;
    logic [31:0]                best_dist;
    logic [rtn_pkg::BARY_W-1:0] best_u, best_v;
    logic [rtn_pkg::IDX_W-1:0]  best_idx, tri_count;
    bit                         any_hit;

    rtn_pkg::out_t results_due[$];
    int            mismatches = 0;
    bit            idle_on = 1;
    longint        cycles = 0;
    rtn_pkg::in_t  prev_tri;

    function automatic longint sat47(longint x);
        if (x > SAT_LIM) return SAT_LIM;
        if (x < -SAT_LIM) return -SAT_LIM;
        return x;
    endfunction

    function automatic longint mul_q16(longint a, longint b);
        logic [127:0] ma, mb, p;
        bit neg;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 128'(-a) : 128'(a);
        mb = (b < 0) ? 128'(-b) : 128'(b);
        p = (ma * mb) >> 16;
        if (p > 128'(SAT_LIM)) p = 128'(SAT_LIM);
        return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
    endfunction

    function automatic void cross3(output longint c[3], input longint a[3], input longint b[3]);
        c[0] = sat47(mul_q16(a[1], b[2]) - mul_q16(a[2], b[1]));
        c[1] = sat47(mul_q16(a[2], b[0]) - mul_q16(a[0], b[2]));
        c[2] = sat47(mul_q16(a[0], b[1]) - mul_q16(a[1], b[0]));
    endfunction

    function automatic longint dot3(input longint a[3], input longint b[3]);
        return sat47(mul_q16(a[0], b[0]) + mul_q16(a[1], b[1]) + mul_q16(a[2], b[2]));
    endfunction

    function automatic void clear_search();
        best_dist = {1'b0, far_lim};
        best_u = '0;
        best_v = '0;
        best_idx = '0;
        any_hit = 0;
        tri_count = '0;
    endfunction

    // one triangle into the search; returns 1 when a result is due
    function automatic bit nearest_hit_step(input rtn_pkg::in_t t, output rtn_pkg::out_t res);
        longint v0[3], v1[3], v2[3], e1[3], e2[3], tv[3], pv[3], qv[3];
        longint det, un, vn, tn;
        logic [63:0] uq, vq, tq;
        int nxt;
        v0 = '{longint'(t.vertex0_x), longint'(t.vertex0_y), longint'(t.vertex0_z)};
        v1 = '{longint'(t.vertex1_x), longint'(t.vertex1_y), longint'(t.vertex1_z)};
        v2 = '{longint'(t.vertex2_x), longint'(t.vertex2_y), longint'(t.vertex2_z)};
        for (int i = 0; i < 3; i++) begin
            e1[i] = v1[i] - v0[i];
            e2[i] = v2[i] - v0[i];
            tv[i] = ray_org[i] - v0[i];
        end
        cross3(pv, ray_dir, e2);
        det = dot3(e1, pv);
        if (det > 0 && det >= longint'({1'b0, det_thr})) begin
            un = dot3(tv, pv);
            if (un >= 0 && un <= det) begin
                cross3(qv, tv, e1);
                vn = dot3(ray_dir, qv);
                if (vn >= 0 && un + vn <= det) begin
                    tn = dot3(e2, qv);
                    if (tn > 0) begin
                        uq = (64'(un) << 16) / 64'(det);
                        vq = (64'(vn) << 16) / 64'(det);
                        tq = (64'(tn) << 16) / 64'(det);
                        if (tq > 0 && tq <= 64'(best_dist)) begin
                            best_dist = tq[31:0];
                            best_u = uq[rtn_pkg::BARY_W-1:0];
                            best_v = vq[rtn_pkg::BARY_W-1:0];
                            best_idx = tri_count;
                            any_hit = 1;
                        end
                    end
                end
            end
        end
        nxt = int'(tri_count) + 1;
        tri_count = (nxt >= IDX_WRAP) ? '0 : nxt[rtn_pkg::IDX_W-1:0];
        res = '0;
        if (!t.last_triangle) return 0;
        if (any_hit) begin
            res.hit_found = 1;
            res.hit_distance = best_dist[rtn_pkg::DIST_W-1:0];
            res.hit_bary_u = best_u;
            res.hit_bary_v = best_v;
            res.hit_triangle_index = best_idx;
        end
        clear_search();
        return 1;
    endfunction

    task automatic reg_write(input reg_idx_e idx, input logic [31:0] val);
        @(posedge aclk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= rtn_pkg::ADDR_W'(4 * int'(idx));
        pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        case (idx)
            REG_ORG_X, REG_ORG_Y, REG_ORG_Z: ray_org[int'(idx)] = longint'($signed(val));
            REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[int'(idx) - 3] = longint'($signed(val));
            REG_FAR_LIMIT: far_lim = val[rtn_pkg::DIST_W-1:0];
            REG_DET_THR: det_thr = val[rtn_pkg::DIST_W-1:0];
            default: ;
        endcase
    endtask

    task automatic send_tri(input rtn_pkg::in_t t, input bit typed, input rtn_pkg::out_t want);
        rtn_pkg::out_t r;
        if (idle_on && $urandom_range(99) < 17) begin
            s_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid <= 1;
        s_payload <= t;
        do @(posedge aclk); while (!s_ready);
        if (nearest_hit_step(t, r)) results_due.push_back(typed ? want : r);
        prev_tri = t;
    endtask

    task automatic drain();
        s_valid <= 0;
        while (results_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    function automatic logic [31:0] q16(int x);
        return 32'(x * 65536);
    endfunction

    function automatic rtn_pkg::in_t mk_tri(int ax, int ay, int az, int bx, int by, int bz,
                                            int cx, int cy, int cz, bit last);
        rtn_pkg::in_t t;
        t.vertex0_x = q16(ax); t.vertex0_y = q16(ay); t.vertex0_z = q16(az);
        t.vertex1_x = q16(bx); t.vertex1_y = q16(by); t.vertex1_z = q16(bz);
        t.vertex2_x = q16(cx); t.vertex2_y = q16(cy); t.vertex2_z = q16(cz);
        t.last_triangle = last;
        return t;
    endfunction

    // triangle around a point on the ray, random shape and winding
    function automatic rtn_pkg::in_t aimed_tri(bit last);
        rtn_pkg::in_t t;
        longint p[3], e1[3], e2[3], v0[3];
        int k, uu, vv;
        k = $urandom_range(0, 24);
        uu = $urandom_range(0, 15);
        vv = $urandom_range(0, 15 - uu);
        for (int i = 0; i < 3; i++) begin
            p[i] = ray_org[i] + ray_dir[i] * k;
            e1[i] = longint'($signed($urandom_range(0, 32 << 16))) - (16 << 16);
            e2[i] = longint'($signed($urandom_range(0, 32 << 16))) - (16 << 16);
            v0[i] = p[i] - (e1[i] * uu + e2[i] * vv) / 16;
        end
        t.vertex0_x = 32'(v0[0]); t.vertex0_y = 32'(v0[1]); t.vertex0_z = 32'(v0[2]);
        t.vertex1_x = 32'(v0[0] + e1[0]);
        t.vertex1_y = 32'(v0[1] + e1[1]);
        t.vertex1_z = 32'(v0[2] + e1[2]);
        t.vertex2_x = 32'(v0[0] + e2[0]);
        t.vertex2_y = 32'(v0[1] + e2[1]);
        t.vertex2_z = 32'(v0[2] + e2[2]);
        t.last_triangle = last;
        return t;
    endfunction

    function automatic rtn_pkg::in_t noise_tri(bit last);
        rtn_pkg::in_t t;
        t = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, $urandom, last};
        return t;
    endfunction

    function automatic logic [31:0] pick_coord(int range_q);
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom;
            default: return 32'($signed($urandom_range(0, 2 * range_q)) - range_q);
        endcase
    endfunction

    task automatic new_ray(int ph);
        logic [31:0] d;
        for (int i = 0; i < 3; i++)
            reg_write(reg_idx_e'(REG_ORG_X + i), 32'($signed($urandom_range(0, 128 << 16))
                      - (64 << 16)));
        for (int i = 0; i < 3; i++) begin
            d = 32'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
            if (i == 2 && d == 0) d = 32'h0001_0000;
            reg_write(reg_idx_e'(REG_DIR_X + i), d);
        end
        if (ph % 5 == 4) begin
            // unusual ray: extreme or full-range components
            reg_write(reg_idx_e'($urandom_range(0, 2)), pick_coord(1 << 24));
            reg_write(reg_idx_e'($urandom_range(3, 5)), pick_coord(1 << 20));
        end
        case (ph % 6)
            0: reg_write(REG_FAR_LIMIT, 32'h7FFF_FFFF);
            1: reg_write(REG_FAR_LIMIT, 32'h0);
            2: reg_write(REG_FAR_LIMIT, 32'd1);
            default: reg_write(REG_FAR_LIMIT, $urandom_range(1, 30 << 16));
        endcase
        case (ph % 7)
            0: reg_write(REG_DET_THR, 32'h0);
            1: reg_write(REG_DET_THR, 32'h7FFF_FFFF);
            2: reg_write(REG_DET_THR, 32'd1);
            3: reg_write(REG_DET_THR, 32'hFFFF_FFFF);
            default: reg_write(REG_DET_THR, $urandom_range(0, 1 << 20));
        endcase
    endtask

    always @(posedge aclk) m_ready <= !idle_on || $urandom_range(99) >= 17;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h", m_payload);
            end else begin
                rtn_pkg::out_t want;
                want = results_due.pop_front();
                if (m_payload.hit_found !== want.hit_found
                        || m_payload.hit_distance !== want.hit_distance
                        || m_payload.hit_bary_u !== want.hit_bary_u
                        || m_payload.hit_bary_v !== want.hit_bary_v
                        || m_payload.hit_triangle_index !== want.hit_triangle_index) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: exp hit=%0d t=%h u=%h v=%h idx=%0d, got hit=%0d t=%h u=%h v=%h idx=%0d",
                                 want.hit_found, want.hit_distance, want.hit_bary_u,
                                 want.hit_bary_v, want.hit_triangle_index,
                                 m_payload.hit_found, m_payload.hit_distance,
                                 m_payload.hit_bary_u, m_payload.hit_bary_v,
                                 m_payload.hit_triangle_index);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYC_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        row_t          dir_rows[$];
        row_t          rw;
        int            len, pick;
        bit            last;
        rtn_pkg::in_t  t;
        ray_org = '{0, 0, 0};
        ray_dir = '{0, 0, 65536};
        far_lim = rtn_pkg::FAR_LIMIT_RST;
        det_thr = rtn_pkg::DET_THR_RST;
        clear_search();
        prev_tri = '0;

        rw.typed = 1;
        rw.want = '0;
        rw.triangle = '0;
        rw.triangle.last_triangle = 1;
        dir_rows.push_back(rw);
        rw.triangle = {{9{32'h7FFF_FFFF}}, 1'b1};
        dir_rows.push_back(rw);
        rw.triangle = {{9{32'h8000_0000}}, 1'b1};
        dir_rows.push_back(rw);
        rw.typed = 0;
        rw.triangle = mk_tri(-1, -1, 5, 1, -1, 5, -1, 1, 5, 0);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(-1, -1, 5, -1, 1, 5, 1, -1, 5, 0);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(-1, -1, 3, -1, 1, 3, 1, -1, 3, 0);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(-1, -1, 3, -1, 1, 3, 1, -1, 3, 1);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(-1, -1, -4, -1, 1, -4, 1, -1, -4, 0);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(-1, -1, -4, 1, -1, -4, -1, 1, -4, 1);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(10, -1, 2, 10, 1, 2, 12, -1, 2, 0);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(-3, 0, 2, 0, 3, 2, 0, -3, 2, 1);
        dir_rows.push_back(rw);
        rw.triangle = mk_tri(0, 0, 7, 0, 2, 7, 2, 0, 7, 1);
        dir_rows.push_back(rw);
        rw.triangle = {32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF,
                       32'h0001_0000, 32'h0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1};
        dir_rows.push_back(rw);

        repeat (9) @(posedge aclk);
        aresetn <= 1;

        foreach (dir_rows[i])
            send_tri(dir_rows[i].triangle, dir_rows[i].typed, dir_rows[i].want);

        for (int ph = 0; ph < 15; ph++) begin
            drain();
            idle_on = !(ph >= 5 && ph <= 7);
            new_ray(ph);
            for (int n = 0; n < 122; ) begin
                len = ($urandom_range(0, 19) == 0) ? 40 : $urandom_range(1, 10);
                for (int j = 0; j < len; j++) begin
                    last = (j == len - 1);
                    pick = $urandom_range(0, 9);
                    if (pick < 8) t = aimed_tri(last);
                    else if (pick == 8) begin
                        t = prev_tri;
                        t.last_triangle = last;
                    end else t = noise_tri(last);
                    send_tri(t, 0, '0);
                    n++;
                end
            end
        end

        drain();
        if (mismatches == 0 && results_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/rtn_pkg.sv
rtl/rtn_queue.sv
rtl/rtn_front.sv
rtl/rtn_back.sv
rtl/ray_triangle_nearest_hit_top.sv
tb/tb_ray_triangle_nearest_hit_top.sv
